// File: design/kcp_pkg.sv
// Package for the 2x2 Kalman covariance prediction block.
// Holds widths, fixed-point constants, register indexes and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package kcp_pkg;

    // field widths
    localparam int COEF_W    = 32;
    localparam int COV_W     = 48;
    localparam int STEP_W    = 10;
    localparam int CFG_IDX_W = 3;

    // fixed-point format and step limit
    localparam int FRAC_BITS = 16;
    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(1023);

    // shared multiplier: coefficient times one 24-bit half of a covariance value
    localparam int HALF_W = 24;
    localparam int OPB_W  = HALF_W + 1;
    localparam int PROD_W = COEF_W + OPB_W;
    localparam int FULL_W = PROD_W + HALF_W + 1;

    // covariance range bounds
    localparam logic [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A00 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A10 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A11 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_G0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_G1  = 3'd5;

    // configuration reset values
    localparam logic [COEF_W-1:0] RST_A00 = 32'd65536;
    localparam logic [COEF_W-1:0] RST_A01 = 32'd65536;
    localparam logic [COEF_W-1:0] RST_A10 = 32'd0;
    localparam logic [COEF_W-1:0] RST_A11 = 32'd65536;
    localparam logic [COEF_W-1:0] RST_G0  = 32'd32768;
    localparam logic [COEF_W-1:0] RST_G1  = 32'd65536;

    // saturated value plus a clip indication
    typedef struct packed {
        logic             clip;
        logic [COV_W-1:0] val;
    } sat_t;

    // clip a wide signed value to the covariance range
    function automatic sat_t sat_cov(input logic signed [FULL_W-1:0] x);
        sat_t r;
        if ((&x[FULL_W-1:COV_W-1]) || !(|x[FULL_W-1:COV_W-1])) begin
            r.clip = 1'b0;
            r.val  = x[COV_W-1:0];
        end
        else begin
            r.clip = 1'b1;
            r.val  = x[FULL_W-1] ? COV_MIN : COV_MAX;
        end
        return r;
    endfunction

endpackage

// File: design/kalman_covariance_predict_2x2.sv
// Top level of the 2x2 Kalman covariance prediction block.
// Iterative datapath around one shared 32x25 signed multiplier; uses kcp_pkg.
`timescale 1ns / 1ps

// Usage
// - input channel: in_valid / in_stall with step_count and the starting covariance;
//   in_stall is high whenever an item is in progress, one item is worked at a time
// - output channel: out_valid / out_stall with the predicted covariance and the
//   saturated flag; the result sits in an output register until taken
// - configuration: cfg_we / cfg_index / cfg_data write A and G at any edge,
//   indexes past the last register are dropped; write only while idle
// - each prediction step runs 8 element updates through the shared multiplier:
//   first the four T elements, then the four P elements
// - the three noise terms G*G^T are formed once per item up front
// - the step count is clipped to the limit (zero counts as one); the block
//   returns to idle after each item before it takes the next one
// - if the receiver stalls while a result waits, the next item still runs and
//   holds in its final state until the output register frees up
// - reset clears the sequencer and out_valid and loads the default A and G
module kalman_covariance_predict_2x2
    import kcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [STEP_W-1:0]        step_count,
    input  logic signed [COV_W-1:0]  cov_in_00,
    input  logic signed [COV_W-1:0]  cov_in_01,
    input  logic signed [COV_W-1:0]  cov_in_10,
    input  logic signed [COV_W-1:0]  cov_in_11,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COV_W-1:0]  cov_out_00,
    output logic signed [COV_W-1:0]  cov_out_01,
    output logic signed [COV_W-1:0]  cov_out_10,
    output logic signed [COV_W-1:0]  cov_out_11,
    output logic                     saturated
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GG,
        ST_TPH,
        ST_QPH,
        ST_DONE
    } state_t;

    // sub-step slots inside one element update
    localparam logic [2:0] SUB_GG_LAST = 3'd3;
    localparam logic [2:0] SUB_T_LAST  = 3'd5;
    localparam logic [2:0] SUB_Q_LAST  = 3'd6;
    localparam logic [1:0] ELEM_GG_LAST = 2'd2;
    localparam logic [1:0] ELEM_LAST    = 2'd3;

    state_t state_reg;
    logic [2:0]        sub_reg;
    logic [1:0]        elem_reg;
    logic [STEP_W-1:0] steps_left_reg;
    logic              sat_reg;
    logic              out_valid_reg;

    // configuration registers
    logic [COEF_W-1:0] a00_reg, a01_reg, a10_reg, a11_reg, g0_reg, g1_reg;

    // working matrices and noise terms
    logic [COV_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [COV_W-1:0] t00_reg, t01_reg, t10_reg, t11_reg;
    logic [COV_W-1:0] gg0_reg, gg1_reg, gg2_reg;

    // arithmetic pipeline registers
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] lo_reg;
    logic [COV_W-1:0]         mres_reg;
    logic [COV_W-1:0]         acc_reg;
    logic [COV_W-1:0]         s_reg;

    // output registers
    logic [COV_W-1:0] out00_reg, out01_reg, out10_reg, out11_reg;
    logic             out_sat_reg;

    logic                     in_accept;
    logic                     out_free;
    logic                     mat_phase;
    logic                     mul_en;
    logic                     lo_en;
    logic                     comb_en;
    logic                     last_sub;
    logic [1:0]               a_sel;
    logic [COEF_W-1:0]        a_op;
    logic [COV_W-1:0]         p_op;
    logic signed [OPB_W-1:0]  b_op;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [FULL_W-1:0] full_prod;
    logic signed [FULL_W-1:0] shifted;
    sat_t                     comb_sat;
    sat_t                     sum_sat;
    sat_t                     gsum_sat;
    logic [COV_W-1:0]         gg_op;
    logic [STEP_W-1:0]        steps_init;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign mat_phase  = (state_reg == ST_TPH) || (state_reg == ST_QPH);

    assign out_valid  = out_valid_reg;
    assign cov_out_00 = $signed(out00_reg);
    assign cov_out_01 = $signed(out01_reg);
    assign cov_out_10 = $signed(out10_reg);
    assign cov_out_11 = $signed(out11_reg);
    assign saturated  = out_sat_reg;

    // clipped step count
    always_comb
    begin
        if (step_count == '0)
            steps_init = STEP_W'(1);
        else if (step_count > MAX_STEPS)
            steps_init = MAX_STEPS;
        else
            steps_init = step_count;
    end

    // slot decode
    always_comb
    begin
        mul_en   = ((state_reg == ST_GG) && (sub_reg <= 3'd1)) ||
                   (mat_phase && (sub_reg <= 3'd3));
        lo_en    = (sub_reg == 3'd1) || (sub_reg == 3'd3);
        comb_en  = ((state_reg == ST_GG) && (sub_reg == 3'd2)) ||
                   (mat_phase && ((sub_reg == 3'd2) || (sub_reg == 3'd4)));
        last_sub = ((state_reg == ST_GG)  && (sub_reg == SUB_GG_LAST)) ||
                   ((state_reg == ST_TPH) && (sub_reg == SUB_T_LAST)) ||
                   ((state_reg == ST_QPH) && (sub_reg == SUB_Q_LAST));
    end

    // operand selection: sub_reg[1] picks the first or second product of the element
    always_comb
    begin
        a_sel = 2'd0;
        p_op  = p00_reg;
        case (state_reg)
            ST_GG:
            begin
                a_sel = (elem_reg == 2'd2) ? 2'd3 : 2'd2;
                p_op  = (elem_reg == 2'd0) ? {{(COV_W-COEF_W){g0_reg[COEF_W-1]}}, g0_reg}
                                           : {{(COV_W-COEF_W){g1_reg[COEF_W-1]}}, g1_reg};
            end
            ST_QPH:
            begin
                a_sel = {elem_reg[0], sub_reg[1]};
                case ({elem_reg[1], sub_reg[1]})
                    2'd0:    p_op = t00_reg;
                    2'd1:    p_op = t01_reg;
                    2'd2:    p_op = t10_reg;
                    default: p_op = t11_reg;
                endcase
            end
            default:
            begin
                a_sel = {elem_reg[1], sub_reg[1]};
                case ({sub_reg[1], elem_reg[0]})
                    2'd0:    p_op = p00_reg;
                    2'd1:    p_op = p01_reg;
                    2'd2:    p_op = p10_reg;
                    default: p_op = p11_reg;
                endcase
            end
        endcase
    end

    // coefficient mux: A entries, then G for the noise terms
    always_comb
    begin
        if (state_reg == ST_GG)
            a_op = a_sel[0] ? g1_reg : g0_reg;
        else begin
            case (a_sel)
                2'd0:    a_op = a00_reg;
                2'd1:    a_op = a01_reg;
                2'd2:    a_op = a10_reg;
                default: a_op = a11_reg;
            endcase
        end
    end

    // shared multiplier: low half unsigned in even slots, high half signed in odd slots
    always_comb
    begin
        if (sub_reg[0])
            b_op = $signed({p_op[COV_W-1], p_op[COV_W-1:HALF_W]});
        else
            b_op = $signed({1'b0, p_op[HALF_W-1:0]});
        prod_next = $signed(a_op) * b_op;
    end

    // recombine halves, floor shift and clip
    always_comb
    begin
        full_prod = $signed({{(FULL_W-PROD_W-HALF_W){prod_reg[PROD_W-1]}}, prod_reg,
                             {HALF_W{1'b0}}})
                  + $signed({{(FULL_W-PROD_W){lo_reg[PROD_W-1]}}, lo_reg});
        shifted   = full_prod >>> FRAC_BITS;
        comb_sat  = sat_cov(shifted);
    end

    // element sums
    always_comb
    begin
        case (elem_reg)
            2'd0:    gg_op = gg0_reg;
            2'd3:    gg_op = gg2_reg;
            default: gg_op = gg1_reg;
        endcase
        sum_sat  = sat_cov($signed({{(FULL_W-COV_W){acc_reg[COV_W-1]}}, acc_reg})
                         + $signed({{(FULL_W-COV_W){mres_reg[COV_W-1]}}, mres_reg}));
        gsum_sat = sat_cov($signed({{(FULL_W-COV_W){s_reg[COV_W-1]}}, s_reg})
                         + $signed({{(FULL_W-COV_W){gg_op[COV_W-1]}}, gg_op}));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a00_reg <= RST_A00;
            a01_reg <= RST_A01;
            a10_reg <= RST_A10;
            a11_reg <= RST_A11;
            g0_reg  <= RST_G0;
            g1_reg  <= RST_G1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_A00: a00_reg <= cfg_data;
                REG_A01: a01_reg <= cfg_data;
                REG_A10: a10_reg <= cfg_data;
                REG_A11: a11_reg <= cfg_data;
                REG_G0:  g0_reg  <= cfg_data;
                REG_G1:  g1_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, step count, flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_reg        <= '0;
            elem_reg       <= '0;
            steps_left_reg <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            // a result loaded from the done state replaces the one being taken
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            if ((comb_en && comb_sat.clip) ||
                ((state_reg == ST_TPH || state_reg == ST_QPH) && sub_reg == 3'd5 &&
                 sum_sat.clip) ||
                ((state_reg == ST_QPH) && sub_reg == 3'd6 && gsum_sat.clip))
                sat_reg <= 1'b1;

            if (state_reg != ST_IDLE && state_reg != ST_DONE)
            begin
                if (last_sub)
                    sub_reg <= '0;
                else
                    sub_reg <= sub_reg + 3'd1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg      <= ST_GG;
                        sub_reg        <= '0;
                        elem_reg       <= '0;
                        steps_left_reg <= steps_init;
                        sat_reg        <= 1'b0;
                    end
                end
                ST_GG:
                begin
                    if (last_sub)
                    begin
                        if (elem_reg == ELEM_GG_LAST)
                        begin
                            elem_reg  <= '0;
                            state_reg <= ST_TPH;
                        end
                        else
                            elem_reg <= elem_reg + 2'd1;
                    end
                end
                ST_TPH:
                begin
                    if (last_sub)
                    begin
                        elem_reg <= elem_reg + 2'd1;
                        if (elem_reg == ELEM_LAST)
                            state_reg <= ST_QPH;
                    end
                end
                ST_QPH:
                begin
                    if (last_sub)
                    begin
                        elem_reg <= elem_reg + 2'd1;
                        if (elem_reg == ELEM_LAST)
                        begin
                            if (steps_left_reg == STEP_W'(1))
                                state_reg <= ST_DONE;
                            else begin
                                steps_left_reg <= steps_left_reg - STEP_W'(1);
                                state_reg      <= ST_TPH;
                            end
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p00_reg <= cov_in_00;
            p01_reg <= cov_in_01;
            p10_reg <= cov_in_10;
            p11_reg <= cov_in_11;
        end

        if (mul_en)
            prod_reg <= prod_next;
        if (lo_en)
            lo_reg <= prod_reg;
        if (comb_en)
            mres_reg <= comb_sat.val;
        if (mat_phase && sub_reg == 3'd3)
            acc_reg <= mres_reg;

        // noise terms
        if (state_reg == ST_GG && sub_reg == SUB_GG_LAST)
        begin
            case (elem_reg)
                2'd0:    gg0_reg <= mres_reg;
                2'd1:    gg1_reg <= mres_reg;
                default: gg2_reg <= mres_reg;
            endcase
        end

        // intermediate T = A*P
        if (state_reg == ST_TPH && sub_reg == SUB_T_LAST)
        begin
            case (elem_reg)
                2'd0:    t00_reg <= sum_sat.val;
                2'd1:    t01_reg <= sum_sat.val;
                2'd2:    t10_reg <= sum_sat.val;
                default: t11_reg <= sum_sat.val;
            endcase
        end

        // P = T*A^T + G*G^T
        if (state_reg == ST_QPH && sub_reg == 3'd5)
            s_reg <= sum_sat.val;
        if (state_reg == ST_QPH && sub_reg == SUB_Q_LAST)
        begin
            case (elem_reg)
                2'd0:    p00_reg <= gsum_sat.val;
                2'd1:    p01_reg <= gsum_sat.val;
                2'd2:    p10_reg <= gsum_sat.val;
                default: p11_reg <= gsum_sat.val;
            endcase
        end

        // result item
        if (state_reg == ST_DONE && out_free)
        begin
            out00_reg   <= p00_reg;
            out01_reg   <= p01_reg;
            out10_reg   <= p10_reg;
            out11_reg   <= p11_reg;
            out_sat_reg <= sat_reg;
        end
    end

endmodule

// File: dv/kalman_covariance_predict_2x2_checker.sv
// Checker for the 2x2 Kalman covariance prediction block: watches both channels,
// predicts each result from its own copy of A and G and compares field by field.
// Depends on kcp_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module kalman_covariance_predict_2x2_checker
    import kcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [STEP_W-1:0]        step_count,
    input  logic signed [COV_W-1:0]  cov_in_00,
    input  logic signed [COV_W-1:0]  cov_in_01,
    input  logic signed [COV_W-1:0]  cov_in_10,
    input  logic signed [COV_W-1:0]  cov_in_11,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [COV_W-1:0]  cov_out_00,
    input  logic signed [COV_W-1:0]  cov_out_01,
    input  logic signed [COV_W-1:0]  cov_out_10,
    input  logic signed [COV_W-1:0]  cov_out_11,
    input  logic                     saturated,
    output int                       fails,
    output int                       results_seen
);

    // wide enough for a coefficient times a covariance value
    localparam int WIDE_W = COEF_W + COV_W;
    localparam logic signed [WIDE_W-1:0] COV_HI =
        {{(WIDE_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] COV_LO = ~COV_HI;

    typedef struct packed {
        logic [COV_W-1:0] c00;
        logic [COV_W-1:0] c01;
        logic [COV_W-1:0] c10;
        logic [COV_W-1:0] c11;
        logic             sat;
    } cov_result_t;

    logic signed [COEF_W-1:0] coef [0:5];
    cov_result_t              expected_cov_q [$];
    bit                       clip_hit;

    // clip to the 48-bit covariance range, remembering any clip
    function automatic logic signed [COV_W-1:0] clip_cov(input logic signed [WIDE_W-1:0] x);
        if (x > COV_HI)
        begin
            clip_hit = 1'b1;
            return COV_HI[COV_W-1:0];
        end
        if (x < COV_LO)
        begin
            clip_hit = 1'b1;
            return COV_LO[COV_W-1:0];
        end
        return x[COV_W-1:0];
    endfunction

    // coefficient times covariance, floored by the fraction bits
    function automatic logic signed [COV_W-1:0] mul_frac(input logic signed [COEF_W-1:0] c,
                                                         input logic signed [COV_W-1:0] v);
        logic signed [WIDE_W-1:0] prod;
        prod = c * v;
        return clip_cov(prod >>> FRAC_BITS);
    endfunction

    function automatic logic signed [COV_W-1:0] add_clip(input logic signed [COV_W-1:0] x,
                                                         input logic signed [COV_W-1:0] y);
        logic signed [WIDE_W-1:0] sum;
        sum = x + y;
        return clip_cov(sum);
    endfunction

    // k rounds of P <- A*P*A^T + G*G^T
    function automatic cov_result_t predict_cov(input logic [STEP_W-1:0] k_raw,
                                                input logic signed [COV_W-1:0] p00,
                                                input logic signed [COV_W-1:0] p01,
                                                input logic signed [COV_W-1:0] p10,
                                                input logic signed [COV_W-1:0] p11);
        logic signed [COEF_W-1:0] a [0:1][0:1];
        logic signed [COEF_W-1:0] g [0:1];
        logic signed [COV_W-1:0]  p [0:1][0:1];
        logic signed [COV_W-1:0]  t [0:1][0:1];
        logic signed [COV_W-1:0]  noise [0:1][0:1];
        int                       n;
        cov_result_t              r;
        clip_hit = 1'b0;
        a[0][0] = coef[REG_A00];
        a[0][1] = coef[REG_A01];
        a[1][0] = coef[REG_A10];
        a[1][1] = coef[REG_A11];
        g[0] = coef[REG_G0];
        g[1] = coef[REG_G1];
        p[0][0] = p00;
        p[0][1] = p01;
        p[1][0] = p10;
        p[1][1] = p11;
        // zero counts as one step, the count never exceeds the limit
        n = (k_raw == '0) ? 1 : int'(k_raw);
        if (n > int'(MAX_STEPS))
            n = int'(MAX_STEPS);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                noise[i][j] = mul_frac(g[i], g[j]);
        for (int s = 0; s < n; s++)
        begin
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    t[i][j] = add_clip(mul_frac(a[i][0], p[0][j]), mul_frac(a[i][1], p[1][j]));
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    p[i][j] = add_clip(add_clip(mul_frac(a[j][0], t[i][0]),
                                                mul_frac(a[j][1], t[i][1])),
                                       noise[i][j]);
        end
        r.c00 = p[0][0];
        r.c01 = p[0][1];
        r.c10 = p[1][0];
        r.c11 = p[1][1];
        r.sat = clip_hit;
        return r;
    endfunction

    function automatic int field_bad(input string label, input logic [COV_W-1:0] want,
                                     input logic [COV_W-1:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s expected %h, got %h", $time, label, want, got);
        return 1;
    endfunction

    // register copy, result check, then prediction of newly accepted items
    always @(posedge clk or negedge rst_n)
    begin : watch
        cov_result_t exp_cov;
        int          bad;
        if (!rst_n)
        begin
            coef[REG_A00] <= RST_A00;
            coef[REG_A01] <= RST_A01;
            coef[REG_A10] <= RST_A10;
            coef[REG_A11] <= RST_A11;
            coef[REG_G0]  <= RST_G0;
            coef[REG_G1]  <= RST_G1;
            expected_cov_q.delete();
            fails        <= 0;
            results_seen <= 0;
        end
        else
        begin
            // writes past the last register are dropped
            if (cfg_we && cfg_index <= REG_G1)
                coef[cfg_index] <= cfg_data;

            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_cov_q.size() == 0)
                begin
                    $display("%0t: result with no item outstanding", $time);
                    fails <= fails + 1;
                end
                else
                begin
                    exp_cov = expected_cov_q.pop_front();
                    bad = field_bad("cov_out_00", exp_cov.c00, cov_out_00)
                        + field_bad("cov_out_01", exp_cov.c01, cov_out_01)
                        + field_bad("cov_out_10", exp_cov.c10, cov_out_10)
                        + field_bad("cov_out_11", exp_cov.c11, cov_out_11)
                        + field_bad("saturated", COV_W'(exp_cov.sat), COV_W'(saturated));
                    fails <= fails + bad;
                end
            end

            if (in_valid && !in_stall)
                expected_cov_q.push_back(predict_cov(step_count, cov_in_00, cov_in_01,
                                                     cov_in_10, cov_in_11));
        end
    end

endmodule

// File: dv/kalman_covariance_predict_2x2_tb.sv
// Testbench top for the 2x2 Kalman covariance prediction block: clock, reset,
// coefficient phases, item stimulus, receiver stalls and the verdict.
// Depends on kcp_pkg, the block and kalman_covariance_predict_2x2_checker.
`timescale 1ns / 1ps

module kalman_covariance_predict_2x2_tb;
    import kcp_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASES      = 10;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 200;
    localparam int COEF_SPAN   = 81920;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [COEF_W-1:0]    COEF_ONE     = 32'h0001_0000;
    localparam logic [COEF_W-1:0]    COEF_TOP     = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]    COEF_BOTTOM  = 32'h8000_0000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [COEF_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [STEP_W-1:0]        step_count = '0;
    logic signed [COV_W-1:0]  cov_in_00 = '0;
    logic signed [COV_W-1:0]  cov_in_01 = '0;
    logic signed [COV_W-1:0]  cov_in_10 = '0;
    logic signed [COV_W-1:0]  cov_in_11 = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [COV_W-1:0]  cov_out_00;
    logic signed [COV_W-1:0]  cov_out_01;
    logic signed [COV_W-1:0]  cov_out_10;
    logic signed [COV_W-1:0]  cov_out_11;
    logic                     saturated;

    int                       fails;
    int                       results_seen;
    int                       items_sent = 0;
    int                       cycles = 0;
    int                       hold_left = 0;
    bit                       idle_on = 1'b1;
    bit                       squeeze_req = 1'b0;
    bit                       squeeze_done = 1'b0;
    logic [COEF_W-1:0]        coef_plan [0:5];

    kalman_covariance_predict_2x2 dut (.*);

    kalman_covariance_predict_2x2_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: one long hold-off on request, otherwise random stalls while idle_on is set
    always @(posedge clk)
    begin
        if (squeeze_req && !squeeze_done)
        begin
            squeeze_done <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 17);
    end

    // offer one item after an optional random gap, return once accepted
    task automatic offer_cov(input logic [STEP_W-1:0] k, input logic [COV_W-1:0] c00,
                             input logic [COV_W-1:0] c01, input logic [COV_W-1:0] c10,
                             input logic [COV_W-1:0] c11);
        while (idle_on && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        step_count <= k;
        cov_in_00  <= c00;
        cov_in_01  <= c01;
        cov_in_10  <= c10;
        cov_in_11  <= c11;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    // write the planned coefficients, then junk to the unused indexes
    task automatic load_coefs();
        for (int r = REG_A00; r <= REG_SPARE_HI; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= (r >= REG_SPARE_LO) ? COEF_W'($urandom) : coef_plan[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly short runs, a few medium, rarely long
    function automatic logic [STEP_W-1:0] rand_steps();
        int r;
        r = $urandom_range(255);
        if (r == 0)
            return STEP_W'($urandom_range(MAX_STEPS, 64));
        if (r < 12)
            return STEP_W'($urandom_range(31, 8));
        return STEP_W'($urandom_range(7));
    endfunction

    // full-range, boundary or moderate covariance values
    function automatic logic [COV_W-1:0] rand_cov();
        logic [COV_W-1:0] v;
        int               m;
        v = COV_W'({$urandom, $urandom});
        case ($urandom_range(7))
            0: return v;
            1:
            begin
                case ($urandom_range(3))
                    0: return COV_MAX;
                    1: return COV_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default:
            begin
                m = $urandom_range(40, 8);
                v = v & ((COV_W'(1) << m) - 1);
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    // coefficients within about +-1.25, unity now and then
    function automatic logic [COEF_W-1:0] rand_coef();
        if ($urandom_range(7) == 0)
            return COEF_ONE;
        return COEF_W'($urandom_range(2 * COEF_SPAN)) - COEF_W'(COEF_SPAN);
    endfunction

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("kalman_covariance_predict_2x2 test failed");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items on the reset coefficients
        offer_cov('0, '0, '0, '0, '0);
        offer_cov(STEP_W'(1), COV_MAX, COV_MAX, COV_MAX, COV_MAX);
        offer_cov(STEP_W'(1), COV_MIN, COV_MIN, COV_MIN, COV_MIN);
        offer_cov(STEP_W'(2), '1, '1, '1, '1);
        offer_cov(STEP_W'(3), COV_MAX, COV_MIN, '0, '1);
        offer_cov(STEP_W'(1), 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                  48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        offer_cov(STEP_W'(7), 48'h0000_0001_0000, 48'hFFFF_FFFF_8000,
                  48'h0000_0000_4000, 48'h0000_0002_0000);
        offer_cov(MAX_STEPS, '0, '0, '0, '0);
        offer_cov(STEP_W'(4), 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF,
                  48'h7FFF_FFFF_0000, 48'h8000_0000_FFFF);
        wait_drained();

        // random items over several coefficient settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int r = REG_A00; r <= REG_G1; r++)
            begin
                case (phase)
                    0: coef_plan[r] = COEF_TOP;
                    1: coef_plan[r] = COEF_BOTTOM;
                    5: coef_plan[r] = COEF_W'($urandom);
                    default: coef_plan[r] = rand_coef();
                endcase
            end
            if (phase == 2)
            begin
                coef_plan[REG_G0] = COEF_TOP;
                coef_plan[REG_G1] = COEF_BOTTOM;
            end
            if (phase == PHASES - 1)
            begin
                coef_plan[REG_A00] = RST_A00;
                coef_plan[REG_A01] = RST_A01;
                coef_plan[REG_A10] = RST_A10;
                coef_plan[REG_A11] = RST_A11;
                coef_plan[REG_G0]  = RST_G0;
                coef_plan[REG_G1]  = RST_G1;
            end
            load_coefs();
            // no idling at all through one phase, a long receiver hold in another
            idle_on <= (phase != 6);
            if (phase == 3)
                squeeze_req <= 1'b1;
            repeat ((phase < 2) ? 30 : 174)
                offer_cov(rand_steps(), rand_cov(), rand_cov(), rand_cov(), rand_cov());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("kalman_covariance_predict_2x2 test passed");
        else
            $display("kalman_covariance_predict_2x2 test failed");
        $finish;
    end

endmodule

// File: kalman_covariance_predict_2x2.f
design/kcp_pkg.sv
design/kalman_covariance_predict_2x2.sv
dv/kalman_covariance_predict_2x2_checker.sv
dv/kalman_covariance_predict_2x2_tb.sv
